/* hdl/assert_macros.svh */
// assertion macros shared by the memory bank decoder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// clocked assertion, checked on every edge including reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* hdl/mbd_pkg.sv */
// types, bank map table and region constants for the memory bank decoder
// no dependencies; imported by every mbd module
package mbd_pkg;

  localparam int unsigned REGIONS  = 7;
  localparam int unsigned ROWS     = 32;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned OFFS_W   = 13;
  localparam int unsigned IDX_W    = 5;

  // bank kind of a region
  typedef enum logic [2:0] {
    KIND_RAM    = 3'd0,
    KIND_BASIC  = 3'd1,
    KIND_IO     = 3'd2,
    KIND_KERNAL = 3'd3,
    KIND_CHAR   = 3'd4,
    KIND_OPEN   = 3'd5,
    KIND_CLO    = 3'd6,
    KIND_CHI    = 3'd7
  } kind_e;

  typedef logic [2:0] region_t;

  // region codes, low address to high
  localparam region_t REGION_00 = 3'd0;
  localparam region_t REGION_10 = 3'd1;
  localparam region_t REGION_80 = 3'd2;
  localparam region_t REGION_A0 = 3'd3;
  localparam region_t REGION_C0 = 3'd4;
  localparam region_t REGION_D0 = 3'd5;
  localparam region_t REGION_E0 = 3'd6;

  // first page of each region
  localparam logic [7:0] PAGE_10 = 8'h10;
  localparam logic [7:0] PAGE_80 = 8'h80;
  localparam logic [7:0] PAGE_A0 = 8'ha0;
  localparam logic [7:0] PAGE_C0 = 8'hc0;
  localparam logic [7:0] PAGE_D0 = 8'hd0;
  localparam logic [7:0] PAGE_E0 = 8'he0;

  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t REGION_BASE [REGIONS] = '{
    16'h0000, 16'h1000, 16'h8000, 16'ha000, 16'hc000, 16'hd000, 16'he000
  };

  // configuration register indexes
  localparam logic CFG_GAME  = 1'b0;
  localparam logic CFG_EXROM = 1'b1;

  typedef kind_e kind_row_t [REGIONS];

  // bank map, one row per pin combination, regions 00 10 80 a0 c0 d0 e0
  localparam kind_row_t BANK_MAP [ROWS] = '{
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_CHI,    KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_CLO, KIND_CHI,    KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_IO,   KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_CHI,    KIND_RAM,  KIND_IO,   KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_CLO, KIND_CHI,    KIND_RAM,  KIND_IO,   KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_CHAR, KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_CLO, KIND_BASIC,  KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_IO,   KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_IO,   KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_CLO, KIND_BASIC,  KIND_RAM,  KIND_IO,   KIND_KERNAL},
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_OPEN, KIND_CLO, KIND_OPEN,   KIND_OPEN, KIND_IO,   KIND_CHI   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_CHAR, KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_BASIC,  KIND_RAM,  KIND_CHAR, KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_RAM,  KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_IO,   KIND_RAM   },
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_RAM,    KIND_RAM,  KIND_IO,   KIND_KERNAL},
    '{KIND_RAM, KIND_RAM,  KIND_RAM, KIND_BASIC,  KIND_RAM,  KIND_IO,   KIND_KERNAL}
  };

  // row used before the first access: all pins high
  localparam logic [IDX_W-1:0] IDX_RESET = 5'd31;

  // registered access, as held in the input stage
  typedef struct packed {
    addr_t            addr;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] prev_idx;
  } access_t;

  // decoded result of one access
  typedef struct packed {
    kind_e             kind;
    logic [OFFS_W-1:0] offset;
    logic              basic_mapped;
    logic [2:0]        changed_mask;
  } result_t;

endpackage

/* hdl/mbd_in_stage.sv */
// input register stage: captures the access, forms the row index, tracks the previous row
// depends on mbd_pkg
module mbd_in_stage
  import mbd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  addr_t      address_i,
  input  logic       loram_i,
  input  logic       hiram_i,
  input  logic       charen_i,
  input  logic       cart_game_i,
  input  logic       cart_exrom_i,
  input  logic       advance_i,
  output logic       valid_o,
  output access_t    access_o
);

  logic             valid_q, valid_d;
  access_t          access_q;
  logic [IDX_W-1:0] prev_q;
  logic [IDX_W-1:0] idx;
  logic             accept;

  // hold off the source only while a held transaction cannot move on
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign idx        = {cart_exrom_i, cart_game_i, charen_i, hiram_i, loram_i};
  assign valid_d    = accept | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      prev_q  <= IDX_RESET;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        prev_q <= idx;
      end
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      access_q.addr     <= address_i;
      access_q.idx      <= idx;
      access_q.prev_idx <= prev_q;
    end
  end

  assign valid_o  = valid_q;
  assign access_o = access_q;

endmodule

/* hdl/mbd_decode.sv */
// region decode and bank map lookup for one registered access
// depends on mbd_pkg
module mbd_decode
  import mbd_pkg::*;
(
  input  access_t access_i,
  output result_t result_o
);

  logic [7:0] page;
  region_t    region;
  kind_row_t  row_now;
  kind_row_t  row_was;
  addr_t      diff;

  assign page    = access_i.addr[ADDR_W-1:ADDR_W-8];
  assign row_now = BANK_MAP[access_i.idx];
  assign row_was = BANK_MAP[access_i.prev_idx];

  // priority decode of the page into a region
  always_comb begin
    if (page >= PAGE_E0) begin
      region = REGION_E0;
    end else if (page >= PAGE_D0) begin
      region = REGION_D0;
    end else if (page >= PAGE_C0) begin
      region = REGION_C0;
    end else if (page >= PAGE_A0) begin
      region = REGION_A0;
    end else if (page >= PAGE_80) begin
      region = REGION_80;
    end else if (page >= PAGE_10) begin
      region = REGION_10;
    end else begin
      region = REGION_00;
    end
  end

  // offset from region base; the wide region wraps to the low bits
  assign diff = access_i.addr - REGION_BASE[region];

  always_comb begin
    result_o.kind            = row_now[region];
    result_o.offset          = diff[OFFS_W-1:0];
    result_o.basic_mapped    = (row_now[REGION_A0] == KIND_BASIC);
    result_o.changed_mask[0] = (row_now[REGION_A0] != row_was[REGION_A0]);
    result_o.changed_mask[1] = (row_now[REGION_D0] != row_was[REGION_D0]);
    result_o.changed_mask[2] = (row_now[REGION_E0] != row_was[REGION_E0]);
  end

endmodule

/* hdl/mbd_out_stage.sv */
// result register stage with its output handshake
// depends on mbd_pkg
module mbd_out_stage
  import mbd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t result_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  // the register moves whenever it is empty or being taken
  assign advance_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* hdl/memory_bank_decoder.sv */
// top level of the memory bank decoder: config registers, input stage, decode, result stage
// depends on mbd_pkg, mbd_in_stage, mbd_decode, mbd_out_stage and assert_macros.svh
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | sink      | in_valid_i / in_stall_o | address, loram, hiram, charen
//  out     | source    | out_valid_o / out_stall_i | region_kind, rom_offset, basic_mapped,
//          |           |                        | changed_mask
//  cfg     | sink      | cfg_we_i               | cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while out_stall_i is low; each result passes through
// the input register, then the table lookup into the result register, before it reaches
// the outputs
// reset sets both cartridge lines high and the previous row to all pins high
// a stalled output holds the result; the input register still takes one transaction if it
// is empty before the input stalls
`include "assert_macros.svh"

module memory_bank_decoder
  import mbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [15:0]       in_address_i,
  input  logic              in_loram_i,
  input  logic              in_hiram_i,
  input  logic              in_charen_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        out_region_kind_o,
  output logic [12:0]       out_rom_offset_o,
  output logic              out_basic_mapped_o,
  output logic [2:0]        out_changed_mask_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i
);

  logic    cart_game_q;
  logic    cart_exrom_q;
  logic    s1_valid;
  access_t s1_access;
  logic    advance;
  result_t dec_result;
  result_t out_result;

  // cartridge line registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_game_q  <= 1'b1;
      cart_exrom_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GAME:  cart_game_q  <= cfg_data_i;
        CFG_EXROM: cart_exrom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mbd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (in_address_i),
    .loram_i      (in_loram_i),
    .hiram_i      (in_hiram_i),
    .charen_i     (in_charen_i),
    .cart_game_i  (cart_game_q),
    .cart_exrom_i (cart_exrom_q),
    .advance_i    (advance),
    .valid_o      (s1_valid),
    .access_o     (s1_access)
  );

  mbd_decode u_decode (
    .access_i (s1_access),
    .result_o (dec_result)
  );

  mbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .result_i    (dec_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign out_region_kind_o  = out_result.kind;
  assign out_rom_offset_o   = out_result.offset;
  assign out_basic_mapped_o = out_result.basic_mapped;
  assign out_changed_mask_o = out_result.changed_mask;

  // a basic region kind can only come from a row that maps basic
  `ASSERT_RST(a_basic_kind_mapped, clk_i, rst_ni,
    (out_valid_o && out_region_kind_o == KIND_BASIC) |-> out_basic_mapped_o)

  // a transaction into an empty pipe passes through the input register, then reaches the output
  `ASSERT_RST(a_empty_latency, clk_i, rst_ni,
    (in_valid_i && !in_stall_o && !s1_valid && !out_valid_o) |=> s1_valid ##1 out_valid_o)

  // a held input-stage transaction keeps its payload until it moves on
  `ASSERT_RST(a_s1_hold, clk_i, rst_ni,
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_access)))

endmodule
